[rtl/wgrl_pkg.sv]
// Shared types and constants for the window group rank limit filter.
// No dependencies; every other file depends on this package.
package wgrl_pkg;

	localparam int KEY_W      = 64;
	localparam int RANK_W     = 32;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 32;
	localparam int MODE_W     = 2;

	// rank rule codes
	localparam logic [MODE_W-1:0] MODE_ROW_NUMBER = 2'd0;
	localparam logic [MODE_W-1:0] MODE_RANK       = 2'd1;
	localparam logic [MODE_W-1:0] MODE_DENSE_RANK = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_RANK_MODE = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROW_LIMIT = 8'd1;

	// how a row relates to the one before it
	typedef struct packed {
		logic new_part;
		logic same_order;
	} wgrl_cls_t;

endpackage

[rtl/wgrl_ifs.sv]
// Valid/ready channel interfaces: row requests, result requests, config writes.
// Depends on wgrl_pkg for field widths.
interface wgrl_in_if;
	logic                         valid;
	logic                         ready;
	logic [wgrl_pkg::KEY_W-1:0]   partition_key;
	logic [wgrl_pkg::KEY_W-1:0]   order_key;
	modport source (output valid, output partition_key, output order_key, input ready);
	modport sink   (input valid, input partition_key, input order_key, output ready);
endinterface

interface wgrl_out_if;
	logic                          valid;
	logic                          ready;
	logic                          keep;
	logic [wgrl_pkg::RANK_W-1:0]   row_rank;
	modport source (output valid, output keep, output row_rank, input ready);
	modport sink   (input valid, input keep, input row_rank, output ready);
endinterface

interface wgrl_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [wgrl_pkg::CFG_IDX_W-1:0]    index;
	logic [wgrl_pkg::CFG_DATA_W-1:0]   data;
	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/window_group_rank_limit_filter.sv]
// Top level of the window group rank limit filter: config registers and wiring.
// Depends on wgrl_pkg, wgrl_ifs, wgrl_front, wgrl_fifo, wgrl_back.
//
// Usage:
//   row_in  carries rows sorted by partition key, then order key. A row request
//           is taken at a rising edge with valid and ready high.
//   res_out returns one request per row: keep and row_rank, in row order.
//   cfg     writes rank_mode (index 0) or row_limit (index 1); other indexes
//           are ignored. cfg.ready is always high; write only while idle.
// Path: a row's class is written to the queue, then the rank unit pops it and
//   registers the result; a pending result in the output register delays the pop.
// Throughput: one row per cycle while res_out.ready stays high; the rank unit
//   computes its rank and peer counter update combinationally from each popped class.
// Reset: rank_mode = row number, row_limit = 1, no previous row, queue empty.
// Stall: a result holds in the output register while res_out.ready is low; the
//   two-entry class queue absorbs rows in flight, and row_in.ready falls only
//   when that queue is full.
module window_group_rank_limit_filter #(
	parameter int KEY_BITS   = 64,
	parameter int COUNT_BITS = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	wgrl_in_if.sink    row_in,
	wgrl_out_if.source res_out,
	wgrl_cfg_if.sink   cfg
);
	import wgrl_pkg::*;

	logic [MODE_W-1:0]     rank_mode_q;
	logic [CFG_DATA_W-1:0] row_limit_q;
	logic                  push;
	logic                  pop;
	logic                  q_full;
	logic                  q_valid;
	wgrl_cls_t             push_cls;
	wgrl_cls_t             pop_cls;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rank_mode_q <= MODE_ROW_NUMBER;
			row_limit_q <= CFG_DATA_W'(1);
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_RANK_MODE: rank_mode_q <= cfg.data[MODE_W-1:0];
				CFG_ROW_LIMIT: row_limit_q <= cfg.data;
				default: ;
			endcase
		end
	end

	wgrl_front #(.KEY_BITS(KEY_BITS)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.row_in   (row_in),
		.q_full   (q_full),
		.push     (push),
		.push_cls (push_cls)
	);

	wgrl_fifo #(.DEPTH(2)) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cls  (push_cls),
		.full      (q_full),
		.pop       (pop),
		.pop_cls   (pop_cls),
		.not_empty (q_valid)
	);

	wgrl_back #(.COUNT_BITS(COUNT_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_cls     (pop_cls),
		.pop       (pop),
		.rank_mode (rank_mode_q),
		.row_limit (row_limit_q),
		.res_out   (res_out)
	);

endmodule

[rtl/wgrl_front.sv]
// Front end: accepts rows, compares keys against the previous row, emits a class.
// Depends on wgrl_pkg and wgrl_in_if.
module wgrl_front #(
	parameter int KEY_BITS = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	wgrl_in_if.sink             row_in,
	input  logic                q_full,
	output logic                push,
	output wgrl_pkg::wgrl_cls_t push_cls
);
	import wgrl_pkg::*;

	logic                seen_any_q;
	logic [KEY_BITS-1:0] last_pkey_q;
	logic [KEY_BITS-1:0] last_okey_q;

	assign row_in.ready = !q_full;
	assign push         = row_in.valid && row_in.ready;

	always_comb begin
		push_cls.new_part   = !seen_any_q ||
			(row_in.partition_key[KEY_BITS-1:0] != last_pkey_q);
		push_cls.same_order = (row_in.order_key[KEY_BITS-1:0] == last_okey_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_any_q <= 1'b0;
		end else if (push) begin
			seen_any_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			last_pkey_q <= row_in.partition_key[KEY_BITS-1:0];
			last_okey_q <= row_in.order_key[KEY_BITS-1:0];
		end
	end

endmodule

[rtl/wgrl_fifo.sv]
// Short queue of row classes between the front end and the rank unit.
// Depends on wgrl_pkg.
module wgrl_fifo #(
	parameter int DEPTH = 2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  wgrl_pkg::wgrl_cls_t push_cls,
	output logic                full,
	input  logic                pop,
	output wgrl_pkg::wgrl_cls_t pop_cls,
	output logic                not_empty
);
	import wgrl_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	wgrl_cls_t        mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_cls   = mem_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		ptr_next = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= ptr_next(wr_ptr_q);
			if (pop)  rd_ptr_q <= ptr_next(rd_ptr_q);
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_cls;
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count did not advance on push");
	a_pop_needs_data: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("pop from empty queue");

endmodule

[rtl/wgrl_back.sv]
// Rank unit: pops row classes, updates rank and peer counters, registers results.
// Depends on wgrl_pkg and wgrl_out_if.
module wgrl_back #(
	parameter int COUNT_BITS = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             q_valid,
	input  wgrl_pkg::wgrl_cls_t              q_cls,
	output logic                             pop,
	input  logic [wgrl_pkg::MODE_W-1:0]      rank_mode,
	input  logic [wgrl_pkg::CFG_DATA_W-1:0]  row_limit,
	wgrl_out_if.source                       res_out
);
	import wgrl_pkg::*;

	localparam int CMP_W = (COUNT_BITS > RANK_W) ? COUNT_BITS : RANK_W;
	localparam logic [CMP_W-1:0] OUT_MAX = CMP_W'({RANK_W{1'b1}});

	logic [COUNT_BITS-1:0] rank_q;
	logic [COUNT_BITS-1:0] peer_q;
	logic [COUNT_BITS-1:0] rank_d;
	logic [COUNT_BITS-1:0] peer_d;
	logic [COUNT_BITS-1:0] rank_inc;
	logic [COUNT_BITS-1:0] rank_gap;
	logic [COUNT_BITS-1:0] peer_inc;
	logic [CMP_W-1:0]      rank_ext;
	logic [CMP_W-1:0]      shown_ext;
	logic                  out_valid_q;
	logic                  out_keep_q;
	logic [RANK_W-1:0]     out_rank_q;

	function automatic logic [COUNT_BITS-1:0] sat_add(input logic [COUNT_BITS-1:0] a,
		input logic [COUNT_BITS-1:0] b);
		logic [COUNT_BITS:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		sat_add = sum[COUNT_BITS] ? {COUNT_BITS{1'b1}} : sum[COUNT_BITS-1:0];
	endfunction

	assign pop = q_valid && (!out_valid_q || res_out.ready);

	always_comb begin
		rank_inc = sat_add(rank_q, COUNT_BITS'(1));
		rank_gap = sat_add(rank_q, peer_q);
		peer_inc = sat_add(peer_q, COUNT_BITS'(1));
		rank_d   = rank_q;
		peer_d   = peer_q;
		if (q_cls.new_part) begin
			rank_d = COUNT_BITS'(1);
			peer_d = COUNT_BITS'(1);
		end else if (rank_mode == MODE_RANK || rank_mode == MODE_DENSE_RANK) begin
			if (q_cls.same_order) begin
				peer_d = peer_inc;
			end else begin
				rank_d = (rank_mode == MODE_RANK) ? rank_gap : rank_inc;
				peer_d = COUNT_BITS'(1);
			end
		end else begin
			// row number, and the unused mode code
			rank_d = rank_inc;
			peer_d = q_cls.same_order ? peer_inc : COUNT_BITS'(1);
		end
		rank_ext  = CMP_W'(rank_d);
		shown_ext = (rank_ext > OUT_MAX) ? OUT_MAX : rank_ext;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rank_q      <= COUNT_BITS'(1);
			peer_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				rank_q      <= rank_d;
				peer_q      <= peer_d;
				out_valid_q <= 1'b1;
			end else if (res_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_keep_q <= (rank_ext <= CMP_W'(row_limit));
			out_rank_q <= shown_ext[RANK_W-1:0];
		end
	end

	assign res_out.valid    = out_valid_q;
	assign res_out.keep     = out_keep_q;
	assign res_out.row_rank = out_rank_q;

	a_new_part_rank_one: assert property (@(posedge clk) disable iff (!arst_n)
		pop && q_cls.new_part |=> rank_q == COUNT_BITS'(1) && peer_q == COUNT_BITS'(1))
		else $error("new partition did not restart rank");
	a_rank_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !q_cls.new_part |=> rank_q >= $past(rank_q))
		else $error("rank fell inside a partition");
	a_no_result_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !res_out.ready |=> out_valid_q && $stable(out_rank_q))
		else $error("pending result overwritten");

endmodule

[tb/window_group_rank_limit_filter_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for window_group_rank_limit_filter: row requests in,
// keep/rank requests checked against an in-bench rank calculator.
// Depends on wgrl_pkg, the wgrl channel interfaces and the filter RTL.
module window_group_rank_limit_filter_tb;
	import wgrl_pkg::*;

	localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;  // undefined code, acts as row number
	localparam logic [RANK_W-1:0] LIMIT_NONE = '0;
	localparam logic [RANK_W-1:0] LIMIT_MAX  = '1;
	localparam int PHASE_ROWS   = 112;
	localparam int RAND_PHASES  = 8;
	localparam int DRAIN_CYCLES = 5;
	localparam int GAP_KEYS [7] = '{1, 1, 2, 3, 3, 3, 4};

	typedef logic [KEY_W-1:0] key_t;
	typedef struct packed {
		key_t pkey;
		key_t okey;
	} row_t;
	typedef struct packed {
		logic              keep;
		logic [RANK_W-1:0] rank;
	} rank_res_t;

	logic clk = 1'b0;
	logic arst_n;

	wgrl_in_if  row_in ();
	wgrl_out_if res_out ();
	wgrl_cfg_if cfg ();

	window_group_rank_limit_filter dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.row_in  (row_in),
		.res_out (res_out),
		.cfg     (cfg)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// stimulus and expectations
	row_t      rows_to_send[$];
	rank_res_t pending_ranks[$];
	row_t      next_row;
	logic      row_taken = 1'b0;
	int        src_idle_pct = 0;
	int        snk_idle_pct = 0;
	int        mismatches = 0;

	// calculator state, mirrors the block after reset
	logic [MODE_W-1:0] calc_mode = MODE_ROW_NUMBER;
	logic [RANK_W-1:0] calc_limit = 1;
	logic              calc_seen = 1'b0;
	key_t              calc_last_pkey = '0;
	key_t              calc_last_okey = '0;
	logic [RANK_W-1:0] calc_rank = 1;
	logic [RANK_W-1:0] calc_peers = '0;

	function automatic logic [RANK_W-1:0] sat_add(logic [RANK_W-1:0] a, logic [RANK_W-1:0] b);
		logic [RANK_W:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		return sum[RANK_W] ? {RANK_W{1'b1}} : sum[RANK_W-1:0];
	endfunction

	task automatic rank_row(input key_t pkey, input key_t okey);
		logic      new_order;
		rank_res_t exp_rec;
		new_order = (okey != calc_last_okey);
		if (!calc_seen || pkey != calc_last_pkey) begin
			calc_rank = 1;
			calc_peers = 1;
		end else if (calc_mode == MODE_RANK || calc_mode == MODE_DENSE_RANK) begin
			if (new_order) begin
				calc_rank = sat_add(calc_rank, (calc_mode == MODE_RANK) ? calc_peers : 1);
				calc_peers = 1;
			end else begin
				calc_peers = sat_add(calc_peers, 1);
			end
		end else begin
			calc_rank = sat_add(calc_rank, 1);
			calc_peers = new_order ? 1 : sat_add(calc_peers, 1);
		end
		calc_seen = 1'b1;
		calc_last_pkey = pkey;
		calc_last_okey = okey;
		exp_rec.keep = (calc_rank <= calc_limit);
		exp_rec.rank = calc_rank;
		pending_ranks.insert(pending_ranks.size(), exp_rec);
	endtask

	// track register writes and accepted rows at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					CFG_RANK_MODE: calc_mode = cfg.data[MODE_W-1:0];
					CFG_ROW_LIMIT: calc_limit = cfg.data[RANK_W-1:0];
					default: ;
				endcase
			end
			if (row_in.valid && row_in.ready)
				rank_row(row_in.partition_key, row_in.order_key);
		end
		row_taken <= arst_n && row_in.valid && row_in.ready;
	end

	// row driver: hold the request until taken, then advance or idle
	always @(negedge clk) begin
		if (!arst_n) begin
			row_in.valid <= 1'b0;
		end else if (!row_in.valid || row_taken) begin
			if (rows_to_send.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
				next_row = rows_to_send.pop_front();
				row_in.valid         <= 1'b1;
				row_in.partition_key <= next_row.pkey;
				row_in.order_key     <= next_row.okey;
			end else begin
				row_in.valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n)
			res_out.ready <= 1'b0;
		else
			res_out.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
	end

	// result monitor
	always @(posedge clk) begin
		rank_res_t exp_res;
		if (arst_n && res_out.valid && res_out.ready) begin
			if (pending_ranks.size() == 0) begin
				$error("result request with nothing expected: keep %0d row_rank %0d",
					res_out.keep, res_out.row_rank);
				mismatches++;
			end else begin
				exp_res = pending_ranks.pop_front();
				if (res_out.keep !== exp_res.keep) begin
					$error("keep: expected %0d, actual %0d", exp_res.keep, res_out.keep);
					mismatches++;
				end
				if (res_out.row_rank !== exp_res.rank) begin
					$error("row_rank: expected %0d, actual %0d", exp_res.rank,
						res_out.row_rank);
					mismatches++;
				end
			end
		end
	end

	function automatic key_t rand_key();
		return {$urandom, $urandom};
	endfunction

	// tiny pool so equal and unequal neighbors both come up often
	function automatic key_t pool_key();
		case ($urandom_range(0, 3))
			0: return '0;
			1: return '1;
			2: return key_t'($urandom_range(1, 3));
			default: return rand_key();
		endcase
	endfunction

	task automatic push_row(input key_t pkey, input key_t okey);
		row_t new_row;
		new_row.pkey = pkey;
		new_row.okey = okey;
		rows_to_send.insert(rows_to_send.size(), new_row);
	endtask

	task automatic queue_partition();
		key_t pkey;
		key_t okey;
		int   peers;
		if ($urandom_range(0, 99) < 15) begin
			repeat ($urandom_range(1, 6)) push_row(pool_key(), pool_key());
		end else begin
			pkey = rand_key();
			okey = rand_key();
			repeat ($urandom_range(1, 6)) begin
				peers = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 9) : $urandom_range(1, 3);
				repeat (peers) push_row(pkey, okey);
				okey = okey + key_t'($urandom_range(1, 1000));
			end
		end
	endtask

	task automatic set_idle(input int src_pct, input int snk_pct);
		src_idle_pct = src_pct;
		snk_idle_pct = snk_pct;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= val;
		do @(posedge clk); while (!cfg.ready);
	endtask

	task automatic set_config(input logic [MODE_W-1:0] mode, input logic [RANK_W-1:0] limit);
		write_reg(CFG_RANK_MODE, CFG_DATA_W'(mode));
		write_reg(CFG_ROW_LIMIT, CFG_DATA_W'(limit));
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	// wait until every queued row is sent and every expected result is back
	task automatic wait_drained();
		do begin
			@(posedge clk);
			#1;
		end while (rows_to_send.size() != 0 || (row_in.valid && !row_taken) ||
			pending_ranks.size() != 0);
	endtask

	initial begin
		#2_000_000;
		$display("status: fail");
		$finish;
	end

	initial begin
		logic [RANK_W-1:0] limit;
		row_in.valid         = 1'b0;
		row_in.partition_key = '0;
		row_in.order_key     = '0;
		res_out.ready        = 1'b0;
		cfg.valid            = 1'b0;
		cfg.index            = '0;
		cfg.data             = '0;
		arst_n               = 1'b0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		// reset settings: row number, limit 1; first row keys equal the cleared history
		set_idle(0, 0);
		push_row('0, '0);
		push_row('0, '0);
		push_row('1, '1);
		push_row('1, '1);
		push_row('1, '0);
		push_row({32{2'b01}}, {32{2'b10}});
		wait_drained();

		// rank with gaps over peer groups
		set_config(MODE_RANK, 3);
		set_idle(53, 0);
		for (int i = 0; i < $size(GAP_KEYS); i++)
			push_row(key_t'(7), key_t'(GAP_KEYS[i]));
		wait_drained();

		// dense rank with a zero limit drops everything
		set_config(MODE_DENSE_RANK, LIMIT_NONE);
		set_idle(0, 53);
		push_row(key_t'(8), key_t'(1));
		push_row(key_t'(8), key_t'(1));
		push_row(key_t'(8), key_t'(2));
		push_row(key_t'(8), key_t'(2));
		push_row(key_t'(8), key_t'(3));
		wait_drained();

		// spare mode code counts rows; same partition carries on across the change
		set_config(MODE_SPARE, LIMIT_MAX);
		set_idle(11, 11);
		push_row(key_t'(8), key_t'(3));
		push_row(key_t'(8), key_t'(3));
		push_row(key_t'(8), key_t'(9));
		wait_drained();

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			case ($urandom_range(0, 5))
				0: limit = LIMIT_NONE;
				1: limit = 1;
				2: limit = $urandom_range(2, 6);
				3: limit = LIMIT_MAX;
				4: limit = $urandom;
				default: limit = $urandom_range(1, 20);
			endcase
			set_config(MODE_W'($urandom_range(0, 3)), limit);
			case (ph % 4)
				0: set_idle(0, 0);
				1: set_idle(53, 0);
				2: set_idle(0, 53);
				default: set_idle(11, 11);
			endcase
			while (rows_to_send.size() < PHASE_ROWS) queue_partition();
			wait_drained();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_ranks.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
